/* sv/first_fit_contiguous_seat_allocator_assert.svh */
// Assertion macros used by the seat allocator controller.
// Define NO_ASSERTIONS to compile them out.
`ifndef FIRST_FIT_CONTIGUOUS_SEAT_ALLOCATOR_ASSERT_SVH
`define FIRST_FIT_CONTIGUOUS_SEAT_ALLOCATOR_ASSERT_SVH

`ifndef NO_ASSERTIONS

// Concurrent check that is ignored while reset is high.
`define FFCSA_ASSERT(lbl, clk, rst, prop, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// Concurrent check that also holds across reset.
`define FFCSA_ASSERT_ALWAYS(lbl, clk, prop, msg) \
   lbl: assert property (@(posedge clk) prop) else $error(msg);

`else

`define FFCSA_ASSERT(lbl, clk, rst, prop, msg)
`define FFCSA_ASSERT_ALWAYS(lbl, clk, prop, msg)

`endif

`endif

/* sv/ffcsa_pkg.sv */
`default_nettype none

package ffcsa_pkg;

   // Field widths of the request and response transactions.
   localparam int RUN_LEN_W = 5;
   localparam int OWNER_W   = 16;
   localparam int POS_W     = 4;

   // Operation codes.
   localparam logic OP_ALLOC   = 1'b0;
   localparam logic OP_RELEASE = 1'b1;

   // Zone codes.
   localparam logic ZONE_A = 1'b0;
   localparam logic ZONE_B = 1'b1;

   // Which value the result register takes.
   typedef enum logic [1:0] {
      RES_FAIL,
      RES_ALLOC,
      RES_RELEASE
   } res_sel_type;

   // Commands from the controller to the datapath.
   typedef struct packed {
      logic        load;
      logic        rd_issue;
      logic        rel_issue;
      logic        write_alloc;
      logic        write_rel;
      logic        res_load;
      res_sel_type res_sel;
      logic        push;
   } cmd_type;

   // Status from the datapath to the controller.
   typedef struct packed {
      logic op_release;
      logic alloc_ok;
      logic rel_ok;
      logic hit;
      logic last_row;
      logic rsp_free;
   } stat_type;

endpackage

`default_nettype wire

/* sv/ffcsa_dpath.sv */
`default_nettype none

module ffcsa_dpath #(
   parameter int ROWS_A        = 16,
   parameter int ROWS_B        = 16,
   parameter int SLOTS_PER_ROW = 16
) (
   input  logic                               clock,
   input  logic                               reset,
   input  ffcsa_pkg::cmd_type                 cmd,
   output ffcsa_pkg::stat_type                stat,
   input  logic                               req_opcode,
   input  logic                               req_zone,
   input  logic [ffcsa_pkg::RUN_LEN_W-1:0]    req_len,
   input  logic [ffcsa_pkg::OWNER_W-1:0]      req_owner,
   input  logic [ffcsa_pkg::POS_W-1:0]        req_rel_row,
   input  logic [ffcsa_pkg::POS_W-1:0]        req_rel_col,
   input  logic                               rsp_tready,
   output logic                               rsp_tvalid,
   output logic                               rsp_found,
   output logic [ffcsa_pkg::POS_W-1:0]        rsp_row,
   output logic [ffcsa_pkg::POS_W-1:0]        rsp_col
);
   import ffcsa_pkg::*;

   localparam int S        = SLOTS_PER_ROW;
   localparam int ROWS_MAX = (ROWS_A > ROWS_B) ? ROWS_A : ROWS_B;
   localparam int ROW_W    = (ROWS_MAX > 1) ? $clog2(ROWS_MAX) : 1;
   localparam int IA_W     = (ROWS_A > 1) ? $clog2(ROWS_A) : 1;
   localparam int IB_W     = (ROWS_B > 1) ? $clog2(ROWS_B) : 1;
   localparam int COL_W    = (S > 1) ? $clog2(S) : 1;
   localparam int MASK_W   = S + 32;
   localparam logic [ROW_W-1:0] LAST_A = ROW_W'(ROWS_A - 1);
   localparam logic [ROW_W-1:0] LAST_B = ROW_W'(ROWS_B - 1);

   // Latched request.
   logic                 op_ff;
   logic                 zone_ff;
   logic [RUN_LEN_W-1:0] len_ff;
   logic                 owner_nz_ff;
   logic [POS_W-1:0]     rel_row_ff;
   logic [POS_W-1:0]     rel_col_ff;

   // Scan pointers: row being read and row whose data is being checked.
   logic [ROW_W-1:0]     rd_row_ff;
   logic [ROW_W-1:0]     chk_row_ff;
   logic [ROW_W-1:0]     rd_addr;
   logic                 rd_en;

   // Occupancy maps: one bit per slot, set while the slot holds an owner.
   logic [S-1:0]         zone_a_mem [ROWS_A];
   logic [S-1:0]         zone_b_mem [ROWS_B];
   logic [ROWS_A-1:0]    vld_a_ff;
   logic [ROWS_B-1:0]    vld_b_ff;
   logic [S-1:0]         rd_a_ff;
   logic [S-1:0]         rd_b_ff;
   logic                 rd_vld_a_ff;
   logic                 rd_vld_b_ff;

   logic [S-1:0]         row_bits;
   logic [MASK_W-1:0]    len_ones;
   logic [MASK_W-1:0]    rel_mask_w;
   logic [S-1:0]         rel_mask;
   logic [S-1:0]         alloc_mask;
   logic [S-1:0]         wr_data;
   logic                 wr_any;
   logic                 wr_a;
   logic                 wr_b;
   logic                 hit;
   logic [COL_W-1:0]     hit_col;
   int                   rows_of_zone;

   // Result held until the output register is free.
   logic                 res_found_ff;
   logic [POS_W-1:0]     res_row_ff;
   logic [POS_W-1:0]     res_col_ff;

   // Output register.
   logic                 rsp_valid_ff;
   logic                 rsp_found_ff;
   logic [POS_W-1:0]     rsp_row_ff;
   logic [POS_W-1:0]     rsp_col_ff;

   // Capture the request; only whether the owner is nonzero matters for occupancy.
   always_ff @(posedge clock) begin
      if (cmd.load) begin
         op_ff       <= req_opcode;
         zone_ff     <= req_zone;
         len_ff      <= req_len;
         owner_nz_ff <= (req_owner != '0);
         rel_row_ff  <= req_rel_row;
         rel_col_ff  <= req_rel_col;
      end
   end

   // Read address: the scan pointer, or the release row.
   assign rd_en   = cmd.rd_issue | cmd.rel_issue;
   assign rd_addr = cmd.rel_issue ? ROW_W'(rel_row_ff) : rd_row_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         rd_row_ff <= '0;
      end else if (cmd.load) begin
         rd_row_ff <= '0;
      end else if (cmd.rd_issue) begin
         rd_row_ff <= rd_row_ff + ROW_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (rd_en) begin
         chk_row_ff <= rd_addr;
      end
   end

   // Write enables per zone; an allocation by owner zero leaves the map unchanged.
   assign wr_any = (cmd.write_alloc & owner_nz_ff) | cmd.write_rel;
   assign wr_a   = wr_any & (zone_ff == ZONE_A);
   assign wr_b   = wr_any & (zone_ff == ZONE_B);

   // Zone A map with registered read.
   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_a_ff <= zone_a_mem[rd_addr[IA_W-1:0]];
      end
      if (wr_a) begin
         zone_a_mem[chk_row_ff[IA_W-1:0]] <= wr_data;
      end
   end

   // Zone B map with registered read.
   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_b_ff <= zone_b_mem[rd_addr[IB_W-1:0]];
      end
      if (wr_b) begin
         zone_b_mem[chk_row_ff[IB_W-1:0]] <= wr_data;
      end
   end

   // Row valid bits; a row never written reads as all free.
   always_ff @(posedge clock) begin
      if (reset) begin
         vld_a_ff <= '0;
         vld_b_ff <= '0;
      end else begin
         if (wr_a) begin
            vld_a_ff[chk_row_ff[IA_W-1:0]] <= 1'b1;
         end
         if (wr_b) begin
            vld_b_ff[chk_row_ff[IB_W-1:0]] <= 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_vld_a_ff <= vld_a_ff[rd_addr[IA_W-1:0]];
         rd_vld_b_ff <= vld_b_ff[rd_addr[IB_W-1:0]];
      end
   end

   always_comb begin
      if (zone_ff == ZONE_B) begin
         row_bits = rd_vld_b_ff ? rd_b_ff : '0;
      end else begin
         row_bits = rd_vld_a_ff ? rd_a_ff : '0;
      end
   end

   // Run masks: a block of len ones, placed at the hit or release column.
   assign len_ones   = (MASK_W'(1) << len_ff) - MASK_W'(1);
   assign rel_mask_w = len_ones << rel_col_ff;
   assign rel_mask   = rel_mask_w[S-1:0];
   assign alloc_mask = len_ones[S-1:0] << hit_col;
   assign wr_data    = cmd.write_rel ? (row_bits & ~rel_mask) : (row_bits | alloc_mask);

   // First fit in the checked row: lowest start column whose window is free.
   always_comb begin
      hit     = 1'b0;
      hit_col = '0;
      for (int c = S - 1; c >= 0; c--) begin
         if (((c + 32'(len_ff)) <= 32'(S)) &&
             (((row_bits >> c) & len_ones[S-1:0]) == '0)) begin
            hit     = 1'b1;
            hit_col = COL_W'(c);
         end
      end
   end

   // Status toward the controller.
   assign rows_of_zone    = (zone_ff == ZONE_B) ? ROWS_B : ROWS_A;
   assign stat.op_release = (op_ff == OP_RELEASE);
   assign stat.alloc_ok   = (len_ff != '0) && (32'(len_ff) <= 32'(S));
   assign stat.rel_ok     = (len_ff != '0) && (32'(rel_row_ff) < 32'(rows_of_zone)) &&
                            (32'(rel_col_ff) < 32'(S));
   assign stat.hit        = hit;
   assign stat.last_row   = (chk_row_ff == ((zone_ff == ZONE_B) ? LAST_B : LAST_A));
   assign stat.rsp_free   = ~rsp_valid_ff | rsp_tready;

   // Result register.
   always_ff @(posedge clock) begin
      if (cmd.res_load) begin
         case (cmd.res_sel)
            RES_ALLOC: begin
               res_found_ff <= 1'b1;
               res_row_ff   <= POS_W'(chk_row_ff);
               res_col_ff   <= POS_W'(hit_col);
            end
            RES_RELEASE: begin
               res_found_ff <= 1'b1;
               res_row_ff   <= rel_row_ff;
               res_col_ff   <= rel_col_ff;
            end
            default: begin
               res_found_ff <= 1'b0;
               res_row_ff   <= '0;
               res_col_ff   <= '0;
            end
         endcase
      end
   end

   // Output register: filled on push, emptied when the transaction completes.
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (cmd.push) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_tready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.push) begin
         rsp_found_ff <= res_found_ff;
         rsp_row_ff   <= res_row_ff;
         rsp_col_ff   <= res_col_ff;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_found  = rsp_found_ff;
   assign rsp_row    = rsp_row_ff;
   assign rsp_col    = rsp_col_ff;

endmodule

`default_nettype wire

/* sv/ffcsa_ctrl.sv */
`default_nettype none

`include "first_fit_contiguous_seat_allocator_assert.svh"

module ffcsa_ctrl (
   input  logic                clock,
   input  logic                reset,
   input  logic                req_tvalid,
   output logic                req_tready,
   input  ffcsa_pkg::stat_type stat,
   output ffcsa_pkg::cmd_type  cmd
);
   import ffcsa_pkg::*;

   typedef enum logic [2:0] {
      IDLE,
      START,
      SCAN,
      RCHK,
      RESP
   } state_type;

   state_type state_ff;
   state_type state_in;
   logic      ready_ff;

   // Next state and commands.
   always_comb begin
      cmd      = '0;
      state_in = state_ff;
      unique case (state_ff)
         IDLE: begin
            // Take a request only at a completed transaction.
            if (req_tvalid && ready_ff) begin
               cmd.load = 1'b1;
               state_in = START;
            end
         end
         START: begin
            if (!stat.op_release) begin
               if (stat.alloc_ok) begin
                  cmd.rd_issue = 1'b1;
                  state_in     = SCAN;
               end else begin
                  cmd.res_load = 1'b1;
                  cmd.res_sel  = RES_FAIL;
                  state_in     = RESP;
               end
            end else if (stat.rel_ok) begin
               cmd.rel_issue = 1'b1;
               state_in      = RCHK;
            end else begin
               cmd.res_load = 1'b1;
               cmd.res_sel  = RES_FAIL;
               state_in     = RESP;
            end
         end
         SCAN: begin
            // One row checked per cycle while the next one is read.
            if (stat.hit) begin
               cmd.write_alloc = 1'b1;
               cmd.res_load    = 1'b1;
               cmd.res_sel     = RES_ALLOC;
               state_in        = RESP;
            end else if (stat.last_row) begin
               cmd.res_load = 1'b1;
               cmd.res_sel  = RES_FAIL;
               state_in     = RESP;
            end else begin
               cmd.rd_issue = 1'b1;
            end
         end
         RCHK: begin
            cmd.write_rel = 1'b1;
            cmd.res_load  = 1'b1;
            cmd.res_sel   = RES_RELEASE;
            state_in      = RESP;
         end
         RESP: begin
            if (stat.rsp_free) begin
               cmd.push = 1'b1;
               state_in = IDLE;
            end
         end
         default: begin
            state_in = IDLE;
         end
      endcase
   end

   // State and registered ready.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= IDLE;
         ready_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         ready_ff <= (state_in == IDLE);
      end
   end

   assign req_tready = ready_ff;

   `FFCSA_ASSERT(a_accept_start, clock, reset, (req_tvalid && req_tready) |=> (state_ff == START), "accepted request did not start")
   `FFCSA_ASSERT(a_scan_after_read, clock, reset, (state_ff == SCAN) |-> $past(cmd.rd_issue), "row checked without a read")
   `FFCSA_ASSERT(a_push_free, clock, reset, cmd.push |-> stat.rsp_free, "push into a full output register")
   `FFCSA_ASSERT_ALWAYS(a_reset_idle, clock, reset |=> (state_ff == IDLE && !req_tready), "reset did not return to idle")

endmodule

`default_nettype wire

/* sv/first_fit_contiguous_seat_allocator.sv */
`default_nettype none

// First-fit seat allocator over two zones of ROWS_A and ROWS_B rows, each row SLOTS_PER_ROW
// slots wide. An allocate request (opcode 0) scans the chosen zone row by row and, within a row,
// from the lowest column for the first run of run_length free slots, marks it taken and returns
// found with row and start column; with no room it returns found 0, row 0, column 0. A release
// request (opcode 1) frees a run in a given row, clipped at the row end, and echoes its row and
// column. Only occupancy is kept: allocating with owner 0 reports the run but leaves it free.
// Each zone is a row-wide memory with a registered read; the scan reads one row per cycle and
// checks the previous one. An allocation with a length of zero or longer than a row, and a
// release whose length is zero or whose row or column is out of range, fails without reading
// the map. Requests are handled one at a time, and a response may wait for a full output
// register. Both maps read as all free right after reset, with no clearing pass. A new request
// is taken while the last response still waits in the output register.
module first_fit_contiguous_seat_allocator #(
   parameter int ROWS_A        = 16,
   parameter int ROWS_B        = 16,
   parameter int SLOTS_PER_ROW = 16
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   // [4:0] run_length, [20:5] owner_id, [24:21] release_row, [28:25] release_column
   input  logic [31:0] req_tdata,
   // [0] opcode, [1] zone_select
   input  logic [1:0]  req_tuser,
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   // [3:0] result_row, [7:4] result_column
   output logic [7:0]  rsp_tdata,
   // [0] found
   output logic        rsp_tuser
);
   import ffcsa_pkg::*;

   cmd_type          cmd;
   stat_type         stat;
   logic [POS_W-1:0] rsp_row;
   logic [POS_W-1:0] rsp_col;

   ffcsa_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .stat       (stat),
      .cmd        (cmd)
   );

   ffcsa_dpath #(
      .ROWS_A        (ROWS_A),
      .ROWS_B        (ROWS_B),
      .SLOTS_PER_ROW (SLOTS_PER_ROW)
   ) u_dpath (
      .clock       (clock),
      .reset       (reset),
      .cmd         (cmd),
      .stat        (stat),
      .req_opcode  (req_tuser[0]),
      .req_zone    (req_tuser[1]),
      .req_len     (req_tdata[4:0]),
      .req_owner   (req_tdata[20:5]),
      .req_rel_row (req_tdata[24:21]),
      .req_rel_col (req_tdata[28:25]),
      .rsp_tready  (rsp_tready),
      .rsp_tvalid  (rsp_tvalid),
      .rsp_found   (rsp_tuser),
      .rsp_row     (rsp_row),
      .rsp_col     (rsp_col)
   );

   // Pack the response fields, lowest field first.
   assign rsp_tdata = {rsp_col, rsp_row};

endmodule

`default_nettype wire
